// ===== src/fdtd1p_pkg.sv =====
// Shared constants, types and saturating arithmetic of the 1-D plasma FDTD block.
// No dependencies; used by the top level and by its port checker.
`timescale 1ns / 1ps
`default_nettype none

package fdtd1p_pkg;

  // Field values and coefficients are Q2.29 in a 32-bit word.
  localparam int unsigned VALUE_W           = 32;
  localparam int unsigned COEF_FRAC         = 29;
  localparam int unsigned MAX_CELLS_DEFAULT = 131072;
  localparam int unsigned MIN_CELLS         = 8;

  // Request and configuration port widths.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CELL_W     = 17;
  localparam int unsigned COUNT_W    = 18;
  localparam int unsigned COEF_W     = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // Request commands.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CELLS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DSUM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DFACT  = 3'd4;

  // Reciprocal of three for 33-bit magnitudes: ceil(2^34 / 3), used with a shift of 34.
  localparam logic [32:0] THIRD_MUL   = 33'd5726623062;
  localparam int unsigned THIRD_SHIFT = 34;

  typedef logic signed [VALUE_W-1:0]   value_t;
  typedef logic signed [VALUE_W:0]     wide_t;
  typedef logic signed [2*VALUE_W-1:0] prod_t;

  localparam value_t VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

  function automatic value_t sat_wide(input wide_t x);
    if (x[VALUE_W] != x[VALUE_W-1]) begin
      return x[VALUE_W] ? VMIN : VMAX;
    end
    return x[VALUE_W-1:0];
  endfunction

  function automatic value_t sat_add(input value_t a, input value_t b);
    wide_t s;
    s = wide_t'(a) + wide_t'(b);
    return sat_wide(s);
  endfunction

  function automatic value_t sat_sub(input value_t a, input value_t b);
    wide_t s;
    s = wide_t'(a) - wide_t'(b);
    return sat_wide(s);
  endfunction

  // floor((a - b) / 2) without overflow.
  function automatic value_t half_diff(input value_t a, input value_t b);
    wide_t d;
    d = wide_t'(a) - wide_t'(b);
    return d[VALUE_W:1];
  endfunction

  // Product scaled by 2^-29, rounded to nearest with ties away from zero, then saturated.
  function automatic value_t round_coef(input prod_t p);
    prod_t r;
    r = p + (p[2*VALUE_W-1] ? prod_t'((64'sd1 <<< (COEF_FRAC - 1)) - 64'sd1)
                            : prod_t'(64'sd1 <<< (COEF_FRAC - 1)));
    r = r >>> COEF_FRAC;
    if ((r[2*VALUE_W-1:VALUE_W-1] != '0) && (r[2*VALUE_W-1:VALUE_W-1] != '1)) begin
      return r[2*VALUE_W-1] ? VMIN : VMAX;
    end
    return r[VALUE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/fdtd_1d_plasma_step.sv =====
// Top level of the 1-D Yee/Drude plasma grid: field and gain memories, sweep
// sequencer and the per-cell update pipeline. Depends on fdtd1p_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block holds a one-dimensional FDTD grid of up to MAX_CELLS cells for a
// collisional plasma. Each cell keeps flux, magnetic field and two
// polarisation samples in one wide synchronous memory, and its plasma gain in
// a second one. A load request writes one gain, and loads may follow each
// other in consecutive cycles. A clear request zeroes the field memory in a
// pass over all MAX_CELLS cells; the same pass runs after reset, so no
// request is taken until it ends (configuration writes are taken
// throughout). A tick request sweeps the K active cells through the field
// memory, one cell per cycle, and returns the electric field at the probe
// cell. The sweep uses the single read port of the field memory, with one
// spare read slot past the last cell, and passes each cell through the
// update pipeline (flux update, Mur edge thirds, polarisation products and
// magnetic update) and the write-back. The next request is taken once the
// result has been moved to the output register. One request is in work at a
// time; a finished result waits in the output register while the next
// request is accepted, and a tick whose result finds that register still
// stalled waits for it. Cells at or beyond K are left alone by a tick.
// Configuration must only be written while the block is idle.
module fdtd_1d_plasma_step #(
  parameter int unsigned MAX_CELLS = fdtd1p_pkg::MAX_CELLS_DEFAULT
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // request channel
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  [fdtd1p_pkg::CMD_W-1:0]          command_i,
  input  wire  [fdtd1p_pkg::CELL_W-1:0]         cell_index_i,
  input  wire  signed [fdtd1p_pkg::VALUE_W-1:0] gain_value_i,
  input  wire  signed [fdtd1p_pkg::VALUE_W-1:0] source_sample_i,
  // result channel
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic signed [fdtd1p_pkg::VALUE_W-1:0] probe_field_o,
  // configuration write channel
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [fdtd1p_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [fdtd1p_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import fdtd1p_pkg::*;

  localparam int unsigned AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned CW = $clog2(MAX_CELLS + 1);
  localparam int unsigned FW = 4 * VALUE_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TICK,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers. The port never pushes back.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] cells_in_use_q;
  logic [CELL_W-1:0]  source_cell_q;
  logic [CELL_W-1:0]  probe_cell_q;
  logic [COEF_W-1:0]  decay_sum_q;
  logic [COEF_W-1:0]  decay_factor_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_in_use_q <= COUNT_W'(104238);
      source_cell_q  <= CELL_W'(5);
      probe_cell_q   <= CELL_W'(5);
      decay_sum_q    <= COEF_W'(1073737529);
      decay_factor_q <= COEF_W'(536866617);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CELLS:  cells_in_use_q <= cfg_data_i[COUNT_W-1:0];
        REG_SOURCE: source_cell_q  <= cfg_data_i[CELL_W-1:0];
        REG_PROBE:  probe_cell_q   <= cfg_data_i[CELL_W-1:0];
        REG_DSUM:   decay_sum_q    <= cfg_data_i[COEF_W-1:0];
        REG_DFACT:  decay_factor_q <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  state_e       state_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] k_q;
  value_t       sample_q;
  value_t       probe_q;
  logic         out_valid_q;
  value_t       probe_field_q;

  logic   in_accept;
  logic   tick_done;
  logic   s5_vld_q;
  logic [CW-1:0] s5_cell_q;
  value_t e_c;
  logic   w_vld_q;
  logic [CW-1:0] w_cell_q;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_accept     = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_valid_q;
  assign probe_field_o = probe_field_q;
  assign tick_done     = w_vld_q && (w_cell_q == k_q - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      cnt_q         <= '0;
      k_q           <= CW'(MIN_CELLS);
      sample_q      <= '0;
      probe_q       <= '0;
      out_valid_q   <= 1'b0;
      probe_field_q <= '0;
    end else begin
      // A taken result is dropped here unless a new one replaces it below.
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      // Probe capture as the cell's electric field leaves its stage.
      if (s5_vld_q && (32'(s5_cell_q) == 32'(probe_cell_q))) begin
        probe_q <= e_c;
      end
      unique case (state_q)
        ST_CLEAR: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(MAX_CELLS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            case (command_i)
              CMD_CLEAR: begin
                cnt_q   <= '0;
                state_q <= ST_CLEAR;
              end
              CMD_TICK: begin
                cnt_q    <= '0;
                sample_q <= source_sample_i;
                probe_q  <= '0;
                if (32'(cells_in_use_q) < 32'(MIN_CELLS)) begin
                  k_q <= CW'(MIN_CELLS);
                end else if (32'(cells_in_use_q) > 32'(MAX_CELLS)) begin
                  k_q <= CW'(MAX_CELLS);
                end else begin
                  k_q <= CW'(cells_in_use_q);
                end
                state_q <= ST_TICK;
              end
              default: ;
            endcase
          end
        end
        ST_TICK: begin
          // One extra read slot runs past the last cell; it is never written back.
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == k_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (tick_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q   <= 1'b1;
            probe_field_q <= probe_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Memories. Field word layout: flux, magnetic, last and previous polarisation.
  // ---------------------------------------------------------------------------
  logic [FW-1:0]      fmem [MAX_CELLS];
  logic [VALUE_W-1:0] gmem [MAX_CELLS];
  logic [FW-1:0]      fmem_rd_q;
  logic [VALUE_W-1:0] gmem_rd_q;
  logic [AW-1:0]      rd_addr;
  logic               fw_en;
  logic [AW-1:0]      fw_addr;
  logic [FW-1:0]      fw_data;
  logic [FW-1:0]      w_data_q;
  logic               gw_en;

  assign rd_addr = AW'(cnt_q);
  assign fw_en   = (state_q == ST_CLEAR) || w_vld_q;
  assign fw_addr = (state_q == ST_CLEAR) ? AW'(cnt_q) : AW'(w_cell_q);
  assign fw_data = (state_q == ST_CLEAR) ? '0 : w_data_q;
  assign gw_en   = in_accept && (command_i == CMD_LOAD) &&
                   (32'(cell_index_i) < 32'(MAX_CELLS));

  always_ff @(posedge clk_i) begin
    fmem_rd_q <= fmem[rd_addr];
    if (fw_en) begin
      fmem[fw_addr] <= fw_data;
    end
  end

  always_ff @(posedge clk_i) begin
    gmem_rd_q <= gmem[rd_addr];
    if (gw_en) begin
      gmem[AW'(cell_index_i)] <= gain_value_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Update pipeline. All stages move together every cycle during a sweep.
  // ---------------------------------------------------------------------------
  logic          rd_vld_q;
  logic [CW-1:0] rd_cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == ST_TICK);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_cell_q <= cnt_q;
  end

  // Stage A: interior flux update and source injection for cell c.
  value_t m_dold, m_h, m_pl, m_pb, m_g;
  value_t a_d1, a_dnew;
  wide_t  a_delta;
  logic   a_inner;
  logic   a_src;
  value_t hprev_q, dprev_q;

  assign m_dold  = fmem_rd_q[4*VALUE_W-1:3*VALUE_W];
  assign m_h     = fmem_rd_q[3*VALUE_W-1:2*VALUE_W];
  assign m_pl    = fmem_rd_q[2*VALUE_W-1:VALUE_W];
  assign m_pb    = fmem_rd_q[VALUE_W-1:0];
  assign m_g     = gmem_rd_q;
  assign a_inner = (rd_cell_q != '0) && (32'(rd_cell_q) + 32'd2 <= 32'(k_q));
  assign a_src   = (32'(rd_cell_q) == 32'(source_cell_q)) &&
                   (32'(source_cell_q) < 32'(k_q));
  assign a_d1    = a_inner ? sat_sub(m_dold, half_diff(m_h, hprev_q)) : m_dold;
  assign a_dnew  = a_src ? sat_add(a_d1, sample_q) : a_d1;
  assign a_delta = wide_t'(dprev_q) - wide_t'(a_dnew);

  logic          s1_vld_q, s2_vld_q;
  logic [CW-1:0] s1_cell_q, s2_cell_q;
  value_t        s1_dold_q, s1_dnew_q, s1_h_q, s1_pl_q, s1_pb_q, s1_g_q;
  wide_t         s1_delta_q, s2_delta_q;
  value_t        s2_dold_q, s2_dnew_q, s2_h_q, s2_pl_q, s2_pb_q, s2_g_q, s2_dold_prev_q;

  // Stage B: Mur edge operands for cell j (held in s2), using cell j+1 from s1 at the left edge.
  logic   b_go, b_edge0, b_edgen;
  wide_t  b_mdelta;
  logic [32:0] b_mag;
  value_t b_old;
  value_t ds_s, df_s;

  assign b_go     = s2_vld_q && (s2_cell_q < k_q);
  assign b_edge0  = (s2_cell_q == '0);
  assign b_edgen  = (s2_cell_q == k_q - CW'(1));
  assign b_mdelta = b_edge0 ? -s1_delta_q : s2_delta_q;
  assign b_mag    = 33'(b_mdelta[VALUE_W] ? -b_mdelta : b_mdelta) + 33'd1;
  assign b_old    = b_edge0 ? s1_dold_q : s2_dold_prev_q;
  assign ds_s     = {1'b0, decay_sum_q};
  assign df_s     = {1'b0, decay_factor_q};

  logic          s3_vld_q, s3_edge_q, s3_neg_q;
  logic [CW-1:0] s3_cell_q;
  logic [32:0]   s3_mag_q;
  value_t        s3_old_q, s3_dnew_q, s3_h_q, s3_pl_q, s3_g_q;
  prod_t         s3_pds_q, s3_pdf_q;

  // Stage C: divide by three, round polarisation products.
  logic [65:0]   c_prod;
  assign c_prod = s3_mag_q * THIRD_MUL;

  logic          s4_vld_q, s4_edge_q, s4_neg_q;
  logic [CW-1:0] s4_cell_q;
  logic [31:0]   s4_q_q;
  value_t        s4_old_q, s4_dnew_q, s4_h_q, s4_pl_q, s4_g_q, s4_rds_q, s4_rdf_q;

  // Stage D: final flux and the decay part of the polarisation recursion.
  value_t d_t, d_dfin;
  assign d_t    = s4_neg_q ? -value_t'(s4_q_q) : value_t'(s4_q_q);
  assign d_dfin = s4_edge_q ? sat_sub(s4_old_q, d_t) : s4_dnew_q;

  value_t        s5_dfin_q, s5_h_q, s5_pl_q, s5_g_q, s5_pn0_q;

  // Stage E: electric field.
  assign e_c = sat_sub(s5_dfin_q, s5_pl_q);

  logic          s6_vld_q;
  logic [CW-1:0] s6_cell_q;
  value_t        s6_e_q, s6_dfin_q, s6_h_q, s6_pl_q, s6_g_q, s6_pn0_q;

  // Stage F: gain product.
  logic          s7_vld_q;
  logic [CW-1:0] s7_cell_q;
  value_t        s7_e_q, s7_dfin_q, s7_h_q, s7_pl_q, s7_pn0_q;
  prod_t         s7_pge_q;

  // Stage G: new polarisation and magnetic field of cell j (E of j+1 sits in s6).
  value_t g_pn, g_hnew;
  assign g_pn   = sat_add(s7_pn0_q, round_coef(s7_pge_q));
  assign g_hnew = (s7_cell_q != k_q - CW'(1)) ?
                  sat_sub(s7_h_q, half_diff(s6_e_q, s7_e_q)) : s7_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      w_vld_q  <= 1'b0;
    end else begin
      s1_vld_q <= rd_vld_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= b_go;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
      w_vld_q  <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // A
    hprev_q    <= m_h;
    dprev_q    <= a_dnew;
    s1_cell_q  <= rd_cell_q;
    s1_dold_q  <= m_dold;
    s1_dnew_q  <= a_dnew;
    s1_delta_q <= a_delta;
    s1_h_q     <= m_h;
    s1_pl_q    <= m_pl;
    s1_pb_q    <= m_pb;
    s1_g_q     <= m_g;
    // cell j copy
    s2_cell_q      <= s1_cell_q;
    s2_dold_q      <= s1_dold_q;
    s2_dold_prev_q <= s2_dold_q;
    s2_dnew_q      <= s1_dnew_q;
    s2_delta_q     <= s1_delta_q;
    s2_h_q         <= s1_h_q;
    s2_pl_q        <= s1_pl_q;
    s2_pb_q        <= s1_pb_q;
    s2_g_q         <= s1_g_q;
    // B
    s3_cell_q <= s2_cell_q;
    s3_edge_q <= b_edge0 || b_edgen;
    s3_neg_q  <= b_mdelta[VALUE_W];
    s3_mag_q  <= b_mag;
    s3_old_q  <= b_old;
    s3_dnew_q <= s2_dnew_q;
    s3_h_q    <= s2_h_q;
    s3_pl_q   <= s2_pl_q;
    s3_g_q    <= s2_g_q;
    s3_pds_q  <= s2_pl_q * ds_s;
    s3_pdf_q  <= s2_pb_q * df_s;
    // C
    s4_cell_q <= s3_cell_q;
    s4_edge_q <= s3_edge_q;
    s4_neg_q  <= s3_neg_q;
    s4_q_q    <= c_prod[THIRD_SHIFT+31:THIRD_SHIFT];
    s4_old_q  <= s3_old_q;
    s4_dnew_q <= s3_dnew_q;
    s4_h_q    <= s3_h_q;
    s4_pl_q   <= s3_pl_q;
    s4_g_q    <= s3_g_q;
    s4_rds_q  <= round_coef(s3_pds_q);
    s4_rdf_q  <= round_coef(s3_pdf_q);
    // D
    s5_cell_q <= s4_cell_q;
    s5_dfin_q <= d_dfin;
    s5_h_q    <= s4_h_q;
    s5_pl_q   <= s4_pl_q;
    s5_g_q    <= s4_g_q;
    s5_pn0_q  <= sat_sub(s4_rds_q, s4_rdf_q);
    // E
    s6_cell_q <= s5_cell_q;
    s6_e_q    <= e_c;
    s6_dfin_q <= s5_dfin_q;
    s6_h_q    <= s5_h_q;
    s6_pl_q   <= s5_pl_q;
    s6_g_q    <= s5_g_q;
    s6_pn0_q  <= s5_pn0_q;
    // F
    s7_cell_q <= s6_cell_q;
    s7_e_q    <= s6_e_q;
    s7_dfin_q <= s6_dfin_q;
    s7_h_q    <= s6_h_q;
    s7_pl_q   <= s6_pl_q;
    s7_pn0_q  <= s6_pn0_q;
    s7_pge_q  <= s6_g_q * s6_e_q;
    // G: write-back word; the old last polarisation becomes the previous one.
    w_cell_q <= s7_cell_q;
    w_data_q <= {s7_dfin_q, g_hnew, g_pn, s7_pl_q};
  end

endmodule

`default_nettype wire

// ===== src/fdtd1p_checker.sv =====
// Port-level checker of the 1-D plasma FDTD block and its bind to the top level.
// Depends on fdtd1p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdtd1p_checker (
  input wire                                   clk_i,
  input wire                                   rst_ni,
  input wire                                   in_valid_i,
  input wire                                   in_stall_o,
  input wire [fdtd1p_pkg::CMD_W-1:0]           command_i,
  input wire                                   out_valid_o,
  input wire                                   out_stall_i,
  input wire signed [fdtd1p_pkg::VALUE_W-1:0]  probe_field_o
);
  import fdtd1p_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(probe_field_o))
    else $error("result dropped or changed while stalled");

  a_out_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(probe_field_o))
    else $error("stalled result changed");

  // A tick sweeps the grid, so the block is busy right after taking one.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (command_i == CMD_TICK) |=> in_stall_o)
    else $error("tick request did not start a sweep");

  // A clear request starts the clearing pass.
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (command_i == CMD_CLEAR) |=> in_stall_o)
    else $error("clear request did not start the clearing pass");

  // A gain load finishes in its own cycle.
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (command_i == CMD_LOAD) |=> !in_stall_o)
    else $error("gain load held the request channel");

endmodule

bind fdtd_1d_plasma_step fdtd1p_checker u_fdtd1p_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .command_i     (command_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .probe_field_o (probe_field_o)
);

`default_nettype wire

// ===== test/fdtd_1d_plasma_step_test.sv =====
// Self-checking testbench for the 1-D plasma FDTD block: a grid predictor
// class checks every probe field result. Depends on fdtd1p_pkg and the DUT.
`timescale 1ns / 1ps

// Holds a full copy of the grid (flux, magnetic field, two polarisation
// samples and the gains) and of the configuration registers. Each accepted
// request is applied to that copy; a tick leaves the predicted probe field in
// a queue, which accepted results are compared against in order.
class plasma_grid_board;
  localparam int unsigned NCELLS = fdtd1p_pkg::MAX_CELLS_DEFAULT;
  localparam longint VHI = 64'sd2147483647;
  localparam longint VLO = -64'sd2147483648;

  longint flux[NCELLS];
  longint magn[NCELLS];
  longint pol_now[NCELLS];
  longint pol_old[NCELLS];
  longint gain[NCELLS];
  int unsigned cells_reg, source_reg, probe_reg;
  longint dsum_reg, dfact_reg;
  fdtd1p_pkg::value_t probe_expected[$];
  int unsigned mismatches;

  function new();
    foreach (flux[i]) begin
      flux[i] = 0; magn[i] = 0; pol_now[i] = 0; pol_old[i] = 0; gain[i] = 0;
    end
    cells_reg = 104238; source_reg = 5; probe_reg = 5;
    dsum_reg = 1073737529; dfact_reg = 536866617;
    mismatches = 0;
  endfunction

  function longint clip(longint v);
    if (v > VHI) return VHI;
    if (v < VLO) return VLO;
    return v;
  endfunction

  function longint halve_diff(longint a, longint b);
    return (a - b) >>> 1;
  endfunction

  // Nearest integer to (a - b) / 3; a third never ties.
  function longint third_diff(longint a, longint b);
    longint d, q, r;
    d = a - b; q = d / 3; r = d % 3;
    if (r == 2) q++;
    else if (r == -2) q--;
    return q;
  endfunction

  // Q2.29 product, rounded to nearest with ties away from zero, saturated.
  function longint coef_mul(longint v, longint c);
    longint p, m, r;
    p = v * c;
    m = (p < 0) ? -p : p;
    r = (m + (64'sd1 <<< 28)) >>> 29;
    if (p < 0) return (r > 64'sd2147483648) ? VLO : -r;
    return (r > VHI) ? VHI : r;
  endfunction

  function void write_reg(logic [2:0] idx, logic [30:0] data);
    case (idx)
      fdtd1p_pkg::REG_CELLS:  cells_reg = data[17:0];
      fdtd1p_pkg::REG_SOURCE: source_reg = data[16:0];
      fdtd1p_pkg::REG_PROBE:  probe_reg = data[16:0];
      fdtd1p_pkg::REG_DSUM:   dsum_reg = data;
      fdtd1p_pkg::REG_DFACT:  dfact_reg = data;
      default: ;
    endcase
  endfunction

  function void time_step(longint sample);
    int unsigned k, i;
    longint old1, oldn, e_prev, probe, pl, e, pn;
    k = (cells_reg < 8) ? 8 : (cells_reg > NCELLS) ? NCELLS : cells_reg;
    old1 = flux[1];
    oldn = flux[k-2];
    for (i = 1; i + 1 < k; i++) flux[i] = clip(flux[i] - halve_diff(magn[i], magn[i-1]));
    if (source_reg < k) flux[source_reg] = clip(flux[source_reg] + sample);
    flux[0] = clip(old1 - third_diff(flux[1], flux[0]));
    flux[k-1] = clip(oldn - third_diff(flux[k-2], flux[k-1]));
    e_prev = 0;
    probe = 0;
    for (i = 0; i < k; i++) begin
      pl = pol_now[i];
      e = clip(flux[i] - pl);
      pn = clip(coef_mul(pl, dsum_reg) - coef_mul(pol_old[i], dfact_reg));
      pn = clip(pn + coef_mul(e, gain[i]));
      pol_old[i] = pl;
      pol_now[i] = pn;
      if (i > 0) magn[i-1] = clip(magn[i-1] - halve_diff(e, e_prev));
      if (i == probe_reg) probe = e;
      e_prev = e;
    end
    probe_expected.push_back(fdtd1p_pkg::value_t'(probe));
  endfunction

  function void accept_request(logic [1:0] cmd, logic [16:0] idx,
                               logic signed [31:0] g, logic signed [31:0] sample);
    case (cmd)
      fdtd1p_pkg::CMD_LOAD: gain[idx] = g;
      fdtd1p_pkg::CMD_CLEAR: begin
        foreach (flux[i]) begin
          flux[i] = 0; magn[i] = 0; pol_now[i] = 0; pol_old[i] = 0;
        end
      end
      fdtd1p_pkg::CMD_TICK: time_step(sample);
      default: ;
    endcase
  endfunction

  function void compare_field(fdtd1p_pkg::value_t actual);
    fdtd1p_pkg::value_t want;
    if (probe_expected.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: probe_field %0d", actual);
      return;
    end
    want = probe_expected.pop_front();
    if (actual !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("probe_field mismatch: expected %0d, got %0d", want, actual);
    end
  endfunction

  function int unsigned pending();
    return probe_expected.size();
  endfunction
endclass

module fdtd_1d_plasma_step_test;
  import fdtd1p_pkg::*;

  // The block gives no name to command 3; it must be ignored.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  // Longest quiet stretch: a clear pass over all cells, with stalls on top.
  localparam int unsigned QUIET_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 80;
  // Cells whose gains are loaded; no tick sweeps beyond them.
  localparam int unsigned GAIN_CELLS = 32;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i, in_stall_o;
  logic [CMD_W-1:0] command_i;
  logic [CELL_W-1:0] cell_index_i;
  logic signed [VALUE_W-1:0] gain_value_i, source_sample_i;
  logic out_valid_o, out_stall_i;
  logic signed [VALUE_W-1:0] probe_field_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  plasma_grid_board board = new();
  bit calm;                 // when set, neither side idles
  int unsigned quiet_cycles = 0;

  fdtd_1d_plasma_step DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Every handshake is observed here, in the active region of the rising
  // edge, so the values seen are those from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        board.accept_request(command_i, cell_index_i, gain_value_i, source_sample_i);
      if (out_valid_o && !out_stall_i) board.compare_field(probe_field_o);
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side: a random stall is drawn for every result, and none while calm.
  initial begin
    int unsigned wait_n;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      wait_n = calm ? 0 : $urandom_range(0, 13);
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Sends one request. The valid stays high into the next request when that
  // one brings no gap, so it is never lowered and raised in one step.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [CELL_W-1:0] idx,
                              logic signed [31:0] g, logic signed [31:0] sample,
                              bit no_gap = 1'b0);
    int unsigned gap;
    gap = (calm || no_gap) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    cell_index_i <= idx;
    gain_value_i <= g;
    source_sample_i <= sample;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Closes a stretch of requests and waits until the block is idle again,
  // so that the configuration may be changed.
  task automatic settle();
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_grid(logic [30:0] cells, logic [30:0] src, logic [30:0] prb,
                          logic [30:0] dsum, logic [30:0] dfact);
    write_reg(REG_CELLS, cells);
    write_reg(REG_SOURCE, src);
    write_reg(REG_PROBE, prb);
    write_reg(REG_DSUM, dsum);
    write_reg(REG_DFACT, dfact);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] any_word();
    case ($urandom_range(0, 4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned n, pick;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    command_i <= CMD_LOAD;
    cell_index_i <= '0;
    gain_value_i <= '0;
    source_sample_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    calm = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Let the clearing pass after reset finish before configuring.
    while (in_stall_o) @(posedge clk_i);

    // Smallest grid (a count below the minimum is clamped), source next to
    // the left edge, probe on the left edge, strongest damping sum.
    set_grid(31'd0, 31'd1, 31'd0, 31'h7fffffff, 31'd0);

    // Every gain a tick can read is written first. The first cells get the
    // extreme gains; the rest is kept moderate so the fields stay lively.
    send_request(CMD_LOAD, 17'd0, 32'sh7fffffff, '0, 1'b1);
    send_request(CMD_LOAD, 17'd1, 32'sh80000000, '0, 1'b1);
    for (n = 2; n < GAIN_CELLS; n++)
      send_request(CMD_LOAD, CELL_W'(n),
                   $signed($urandom_range(0, 32'h07ffffff)) - 32'sh04000000, '0, 1'b1);

    // Directed requests: extreme samples, an ignored command, the top cell
    // index, a clear of the fields and the ticks around it.
    send_request(CMD_TICK, '0, '0, 32'sh7fffffff);
    send_request(CMD_TICK, '0, '0, 32'sh7fffffff);
    send_request(CMD_TICK, '0, '0, 32'sh80000000);
    send_request(CMD_TICK, '0, '0, 32'sh80000000);
    send_request(CMD_TICK, '0, '0, -32'sd1);
    send_request(CMD_SPARE, 17'h1ffff, 32'sh7fffffff, 32'sh7fffffff);
    send_request(CMD_TICK, '0, '0, 32'sd0);
    send_request(CMD_LOAD, 17'h1ffff, 32'sh80000000, '0);
    send_request(CMD_LOAD, 17'd3, 32'sh7fffffff, '0);
    send_request(CMD_TICK, '0, '0, 32'sh12345678);
    send_request(CMD_CLEAR, 17'h1ffff, 32'sh7fffffff, 32'sh7fffffff);
    send_request(CMD_TICK, '0, '0, 32'sh40000000);
    send_request(CMD_TICK, '0, '0, -32'sh40000000);
    settle();

    // Random phases on small grids: source and probe may fall on an edge or
    // beyond the active cells; damping registers are drawn over their range.
    for (int phase = 0; phase < 5; phase++) begin
      calm = (phase == 2);
      set_grid(31'($urandom_range(0, 9) == 0 ? $urandom_range(0, 7)
                                              : $urandom_range(8, GAIN_CELLS)),
               31'($urandom_range(0, 40)), 31'($urandom_range(0, 40)),
               $urandom_range(0, 3) == 0 ? 31'($urandom)
                                         : 31'd1073737529 + 31'($urandom_range(0, 4096)),
               $urandom_range(0, 3) == 0 ? 31'($urandom)
                                         : 31'd536866617 - 31'($urandom_range(0, 4096)));
      for (n = 0; n < 11; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 13)
          send_request(CMD_TICK, CELL_W'($urandom), $urandom, any_word());
        else if (pick < 18)
          send_request(CMD_LOAD, $urandom_range(0, 3) == 0 ? CELL_W'($urandom)
                                                           : CELL_W'($urandom_range(0, 40)),
                       any_word(), $urandom);
        else
          send_request(CMD_SPARE, CELL_W'($urandom), $urandom, $urandom);
      end
      settle();
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/fdtd1p_pkg.sv
src/fdtd_1d_plasma_step.sv
src/fdtd1p_checker.sv
test/fdtd_1d_plasma_step_test.sv
